// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define AWA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define AWA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/awa_pkg.sv -----
// Constants, types and helper functions of the wheel angle pipeline.
package awa_pkg;

	localparam int ANGLE_FRAC_BITS = 8;
	localparam int CORDIC_STAGES   = 16;
	localparam int INT_FRAC        = 24;
	localparam int YAW_SHIFT       = INT_FRAC - ANGLE_FRAC_BITS;
	localparam int RND_SHIFT       = INT_FRAC - ANGLE_FRAC_BITS;

	localparam int ANGLE_W = 16;
	localparam int LEN_W   = 16;

	localparam int ROT_W  = 34;                      // rotation x/y, Q30
	localparam int ZW     = 34;                      // angles, 2^-24 deg
	localparam int QUOT_W = 32;                      // radius quotient bits
	localparam int DIVD_W = LEN_W + ROT_W + 8;       // dividend L*|cos|*256
	localparam int DIVS_W = ROT_W + 1;               // divisor 2*|sin|
	localparam int DIVC_W = DIVS_W + QUOT_W;         // compare width
	localparam int RAD_W  = 32;
	localparam int DEN_W  = RAD_W + 2;
	localparam int VEC_W  = 38;

	localparam int PIPE_DEPTH = 2 * CORDIC_STAGES + QUOT_W + 8;

	localparam logic [LEN_W-1:0] WHEELBASE_RST = 16'd200;
	localparam logic [LEN_W-1:0] TRACK_RST     = 16'd200;

	localparam logic [0:0] REG_WHEELBASE = 1'b0;
	localparam logic [0:0] REG_TRACK     = 1'b1;

	localparam logic signed [39:0] YAW_LIM = 40'sd90 <<< ANGLE_FRAC_BITS;
	localparam logic signed [ROT_W-1:0] TRIG_GAIN = ROT_W'(652032874);
	localparam logic signed [ZW-1:0] Z_RIGHT = ZW'(64'd90 << INT_FRAC);
	localparam logic [ZW-1:0] OUT_MAG_LIM = ZW'(64'd90 << ANGLE_FRAC_BITS);
	localparam logic [ZW-1:0] RND_HALF = ZW'(64'd1 << (RND_SHIFT - 1));

	localparam int OUT_HI = (90 << ANGLE_FRAC_BITS) > 32767 ? 32767 : (90 << ANGLE_FRAC_BITS);
	localparam int OUT_LO = (90 << ANGLE_FRAC_BITS) > 32767 ? -32768 : -(90 << ANGLE_FRAC_BITS);

	localparam logic signed [RAD_W-1:0] RAD_MAX = 32'sh7fff_ffff;
	localparam logic signed [RAD_W-1:0] RAD_MIN = 32'sh8000_0000;

	// round(atan(2^-i) deg * 2^24)
	localparam logic [31:0] ATAN_TBL [32] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934, 32'd30029717, 32'd15018523, 32'd7509720,
		32'd3754917, 32'd1877466, 32'd938734, 32'd469367,
		32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833,
		32'd917, 32'd458, 32'd229, 32'd115,
		32'd57, 32'd29, 32'd14, 32'd7,
		32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef struct packed {
		logic skip;
		logic yaw_pos;
	} meta_t;

	typedef struct packed {
		logic skip;
		logic yaw_pos;
		logic neg;
		logic sin_zero;
		logic ovf;
	} div_flags_t;

	typedef struct packed {
		logic den_zero;
		logic den_neg;
	} vec_flags_t;

	function automatic logic signed [ZW-1:0] atan_z(int i);
		return ZW'(ATAN_TBL[i]);
	endfunction

	// 2^-24 deg to output units: round half away, clamp to 90 deg and int16
	function automatic logic signed [ANGLE_W-1:0] to_output(logic signed [ZW-1:0] z);
		logic [ZW-1:0] m;
		logic signed [ZW:0] sm;
		m = z[ZW-1] ? ZW'(-z) : ZW'(z);
		m = (m + RND_HALF) >> RND_SHIFT;
		if (m > OUT_MAG_LIM) m = OUT_MAG_LIM;
		sm = z[ZW-1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
		if (sm > (ZW+1)'(32767)) sm = (ZW+1)'(32767);
		if (sm < -(ZW+1)'(32768)) sm = -(ZW+1)'(32768);
		return ANGLE_W'(sm);
	endfunction

endpackage

// ----- rtl/awa_if.sv -----
// Command and result channels of the wheel angle block.
interface awa_cmd_if;
	logic valid;
	logic ready;
	logic signed [awa_pkg::ANGLE_W-1:0] yaw_angle;
	modport source (output valid, output yaw_angle, input ready);
	modport sink (input valid, input yaw_angle, output ready);
endinterface

interface awa_res_if;
	logic valid;
	logic ready;
	logic signed [awa_pkg::ANGLE_W-1:0] right_angle;
	logic signed [awa_pkg::ANGLE_W-1:0] left_angle;
	modport source (output valid, output right_angle, output left_angle, input ready);
	modport sink (input valid, input right_angle, input left_angle, output ready);
endinterface

// ----- rtl/ackermann_wheel_angles.sv -----
// Ackermann steering: yaw request in, right and left wheel angles out.
//
// cmd carries one yaw word (1/256 deg, clamped to +-90 deg); res returns one
// word with both wheel angles in the same unit. Wheelbase and track are set
// through the cfg write port (index 0 and 1); the user must do so only while
// the pipe is empty, as the block does not enforce it. The datapath is one
// pipeline of 2*CORDIC_STAGES + 40 register stages: input clamp, rotation
// CORDIC for sin/cos, one multiplier, a restoring divider with one quotient
// bit per stage for the turn radius, then two vectoring CORDICs for the two
// wheels and rounding. A word is taken every cycle; the whole pipe advances
// together, so the throughput is one word per cycle while res is ready.
// When res stalls with a word waiting in the output register, the pipe and
// cmd.ready freeze until that word is taken; nothing is dropped or repeated.
// Reset clears the valid bits and loads both lengths with 200 mm.
`include "assert_macros.svh"

module ackermann_wheel_angles (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [0:0] cfg_idx,
	input  logic [awa_pkg::LEN_W-1:0] cfg_wdata,
	awa_cmd_if.sink cmd,
	awa_res_if.source res
);

	localparam int CS = awa_pkg::CORDIC_STAGES;
	localparam int QW = awa_pkg::QUOT_W;

	logic [awa_pkg::LEN_W-1:0] wheelbase_q, track_q;
	logic en;
	logic [awa_pkg::PIPE_DEPTH-1:0] vld_s;

	// input clamp
	logic signed [39:0] yaw_ext, yaw_cl;
	awa_pkg::meta_t in_meta;

	// rotation CORDIC
	logic signed [awa_pkg::ROT_W-1:0] rx_s [CS+1];
	logic signed [awa_pkg::ROT_W-1:0] ry_s [CS+1];
	logic signed [awa_pkg::ZW-1:0] rz_s [CS+1];
	awa_pkg::meta_t rm_s [CS+1];

	// multiply
	logic [awa_pkg::ROT_W-1:0] c_abs, s_abs;
	logic [awa_pkg::DIVD_W-1:0] mdvd_s;
	logic [awa_pkg::DIVS_W-1:0] mdvs_s;
	awa_pkg::div_flags_t mf_s;

	// divider
	logic [awa_pkg::DIVD_W-1:0] rem_s [QW+1];
	logic [awa_pkg::DIVS_W-1:0] ds_s [QW+1];
	logic [QW-1:0] dq_s [QW+1];
	awa_pkg::div_flags_t df_s [QW+1];

	// radius and denominators
	logic signed [awa_pkg::RAD_W-1:0] rad_c, rad_s;
	logic sat_pos, sat_neg;
	awa_pkg::meta_t radm_s;
	logic signed [awa_pkg::DEN_W-1:0] den_s [2];
	logic den_skip_s;

	// vectoring CORDICs, side 0 right, side 1 left
	logic signed [awa_pkg::VEC_W-1:0] vx_s [2][CS+1];
	logic signed [awa_pkg::VEC_W-1:0] vy_s [2][CS+1];
	logic signed [awa_pkg::ZW-1:0] vz_s [2][CS+1];
	awa_pkg::vec_flags_t vf_s [2][CS+1];
	logic vskip_s [CS+1];

	// output
	logic signed [awa_pkg::ZW-1:0] ang_s [2];
	logic askip_s;
	logic signed [awa_pkg::ANGLE_W-1:0] oright_s, oleft_s;
	logic oskip_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheelbase_q <= awa_pkg::WHEELBASE_RST;
			track_q     <= awa_pkg::TRACK_RST;
		end else if (cfg_we) begin
			if (cfg_idx == awa_pkg::REG_WHEELBASE) begin
				wheelbase_q <= cfg_wdata;
			end
			if (cfg_idx == awa_pkg::REG_TRACK) begin
				track_q <= cfg_wdata;
			end
		end
	end

	assign en        = !vld_s[awa_pkg::PIPE_DEPTH-1] || res.ready;
	assign cmd.ready = en;
	assign res.valid = vld_s[awa_pkg::PIPE_DEPTH-1];
	assign res.right_angle = oright_s;
	assign res.left_angle  = oleft_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[awa_pkg::PIPE_DEPTH-2:0], cmd.valid};
		end
	end

	always_comb begin
		yaw_ext = 40'(cmd.yaw_angle);
		if (yaw_ext > awa_pkg::YAW_LIM) begin
			yaw_cl = awa_pkg::YAW_LIM;
		end else if (yaw_ext < -awa_pkg::YAW_LIM) begin
			yaw_cl = -awa_pkg::YAW_LIM;
		end else begin
			yaw_cl = yaw_ext;
		end
		in_meta.skip    = (yaw_cl == 40'sd0) || (wheelbase_q == '0);
		in_meta.yaw_pos = (yaw_cl > 40'sd0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s[0] <= awa_pkg::TRIG_GAIN;
			ry_s[0] <= '0;
			rz_s[0] <= awa_pkg::ZW'(yaw_cl <<< awa_pkg::YAW_SHIFT);
			rm_s[0] <= in_meta;
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (!rz_s[i][awa_pkg::ZW-1]) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] - awa_pkg::atan_z(i);
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					rz_s[i+1] <= rz_s[i] + awa_pkg::atan_z(i);
				end
				rm_s[i+1] <= rm_s[i];
			end
		end
	end

	// L*|cos|*256 over 2*|sin|, sign kept aside
	assign c_abs = rx_s[CS][awa_pkg::ROT_W-1] ? awa_pkg::ROT_W'(-rx_s[CS])
		: awa_pkg::ROT_W'(rx_s[CS]);
	assign s_abs = ry_s[CS][awa_pkg::ROT_W-1] ? awa_pkg::ROT_W'(-ry_s[CS])
		: awa_pkg::ROT_W'(ry_s[CS]);

	always_ff @(posedge clk) begin
		if (en) begin
			mdvd_s <= {(awa_pkg::LEN_W + awa_pkg::ROT_W)'(wheelbase_q)
				* (awa_pkg::LEN_W + awa_pkg::ROT_W)'(c_abs), 8'b0};
			mdvs_s <= {s_abs, 1'b0};
			mf_s.skip     <= rm_s[CS].skip;
			mf_s.yaw_pos  <= rm_s[CS].yaw_pos;
			mf_s.neg      <= rx_s[CS][awa_pkg::ROT_W-1] ^ ry_s[CS][awa_pkg::ROT_W-1];
			mf_s.sin_zero <= (ry_s[CS] == '0);
			mf_s.ovf      <= 1'b0;
		end
	end

	// quotient would need more than QUOT_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= mdvd_s;
			ds_s[0]  <= mdvs_s;
			dq_s[0]  <= '0;
			df_s[0]  <= '{skip: mf_s.skip, yaw_pos: mf_s.yaw_pos, neg: mf_s.neg,
				sin_zero: mf_s.sin_zero,
				ovf: {(awa_pkg::DIVC_W - awa_pkg::DIVD_W)'(0), mdvd_s}
					>= {mdvs_s, QW'(0)}};
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		logic [awa_pkg::DIVC_W-1:0] trial;
		logic fits;
		assign trial = awa_pkg::DIVC_W'(ds_s[j]) << K;
		assign fits  = {(awa_pkg::DIVC_W - awa_pkg::DIVD_W)'(0), rem_s[j]} >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= fits ? rem_s[j] - awa_pkg::DIVD_W'(trial) : rem_s[j];
				dq_s[j+1]  <= {dq_s[j][QW-2:0], fits};
				ds_s[j+1]  <= ds_s[j];
				df_s[j+1]  <= df_s[j];
			end
		end
	end

	always_comb begin
		sat_pos = df_s[QW].ovf || dq_s[QW][QW-1];
		sat_neg = df_s[QW].ovf || (dq_s[QW][QW-1] && (dq_s[QW][QW-2:0] != '0));
		if (df_s[QW].sin_zero) begin
			rad_c = df_s[QW].yaw_pos ? awa_pkg::RAD_MAX : awa_pkg::RAD_MIN;
		end else if (df_s[QW].neg) begin
			rad_c = sat_neg ? awa_pkg::RAD_MIN : awa_pkg::RAD_W'(~dq_s[QW] + 1'b1);
		end else begin
			rad_c = sat_pos ? awa_pkg::RAD_MAX : awa_pkg::RAD_W'(dq_s[QW]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s  <= rad_c;
			radm_s <= '{skip: df_s[QW].skip, yaw_pos: df_s[QW].yaw_pos};
		end
	end

	// R - track/2 and R + track/2 in Q8
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= awa_pkg::DEN_W'(rad_s) - $signed({11'b0, track_q, 7'b0});
			den_s[1] <= awa_pkg::DEN_W'(rad_s) + $signed({11'b0, track_q, 7'b0});
			den_skip_s <= radm_s.skip;
		end
	end

	for (genvar sd = 0; sd < 2; sd++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) begin
				vx_s[sd][0] <= den_s[sd][awa_pkg::DEN_W-1]
					? awa_pkg::VEC_W'(-den_s[sd]) : awa_pkg::VEC_W'(den_s[sd]);
				vy_s[sd][0] <= awa_pkg::VEC_W'({wheelbase_q, 8'b0});
				vz_s[sd][0] <= '0;
				vf_s[sd][0].den_zero <= (den_s[sd] == '0);
				vf_s[sd][0].den_neg  <= den_s[sd][awa_pkg::DEN_W-1];
			end
		end

		for (genvar i = 0; i < CS; i++) begin : g_vec
			always_ff @(posedge clk) begin
				if (en) begin
					if (!vy_s[sd][i][awa_pkg::VEC_W-1]) begin
						vx_s[sd][i+1] <= vx_s[sd][i] + (vy_s[sd][i] >>> i);
						vy_s[sd][i+1] <= vy_s[sd][i] - (vx_s[sd][i] >>> i);
						vz_s[sd][i+1] <= vz_s[sd][i] + awa_pkg::atan_z(i);
					end else begin
						vx_s[sd][i+1] <= vx_s[sd][i] - (vy_s[sd][i] >>> i);
						vy_s[sd][i+1] <= vy_s[sd][i] + (vx_s[sd][i] >>> i);
						vz_s[sd][i+1] <= vz_s[sd][i] - awa_pkg::atan_z(i);
					end
					vf_s[sd][i+1] <= vf_s[sd][i];
				end
			end
		end

		// zero denominator pins the wheel at 90 deg
		always_ff @(posedge clk) begin
			if (en) begin
				if (vf_s[sd][CS].den_zero) begin
					ang_s[sd] <= awa_pkg::Z_RIGHT;
				end else if (vf_s[sd][CS].den_neg) begin
					ang_s[sd] <= -vz_s[sd][CS];
				end else begin
					ang_s[sd] <= vz_s[sd][CS];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vskip_s[0] <= den_skip_s;
		end
	end

	for (genvar i = 0; i < CS; i++) begin : g_vskip
		always_ff @(posedge clk) begin
			if (en) begin
				vskip_s[i+1] <= vskip_s[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			askip_s <= vskip_s[CS];
			oskip_s <= askip_s;
			if (askip_s) begin
				oright_s <= '0;
				oleft_s  <= '0;
			end else begin
				oright_s <= awa_pkg::to_output(ang_s[0]);
				oleft_s  <= awa_pkg::ANGLE_W'(-awa_pkg::to_output(ang_s[1]));
			end
		end
	end

	`AWA_ASSERT_NEXT(a_accept_enters, cmd.valid && cmd.ready, vld_s[0])
	`AWA_ASSERT_NEXT(a_stall_freezes, res.valid && !res.ready, $stable(vld_s))
	`AWA_ASSERT_NOW(a_skip_zero, res.valid && oskip_s,
		res.right_angle == '0 && res.left_angle == '0)
	`AWA_ASSERT_NOW(a_right_range, res.valid,
		$signed(res.right_angle) <= awa_pkg::OUT_HI && $signed(res.right_angle) >= awa_pkg::OUT_LO)

endmodule
